// ===== design/ltq_pkg.sv =====
// Shared constants and types for the line-to-quad expander.
// No dependencies; imported by ltq_search and line_to_quad_expander_unit.
package ltq_pkg;

  localparam int COORD_BITS = 24;
  localparam int WIDTH_BITS = 16;
  localparam int RGBA_BITS  = 32;
  localparam int CFG_BITS   = 24;
  localparam int NORM_BITS  = (WIDTH_BITS > 15) ? (30 - WIDTH_BITS) : 15;
  localparam int SMALL_BITS = 12;
  localparam int EXPAND     = 512;

  localparam logic [CFG_BITS-1:0] MIN_LEN_RESET = CFG_BITS'(66);

  localparam int AW  = COORD_BITS + 1;
  localparam int EW  = ((WIDTH_BITS > 9) ? WIDTH_BITS : 9) + 1;
  localparam int QW  = WIDTH_BITS + 1;
  localparam int SW  = 2 * NORM_BITS + 1;
  localparam int PW  = NORM_BITS + EW;
  localparam int RW  = 2 * PW;
  localparam int CW  = (2 * QW + 2 + SW > RW) ? (2 * QW + 2 + SW) : RW;
  localparam int KW  = $clog2(AW + 1);
  localparam int SQW = 2 * SMALL_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic [WIDTH_BITS-1:0]        w;
    logic [RGBA_BITS-1:0]         rgba;
    logic                         last;
    logic                         skip;
    logic                         zero;
    logic                         dxpos;
    logic                         dyneg;
  } side_t;

endpackage

// ===== design/ltq_search.sv =====
// Pipelined bit-by-bit search of both normal offset magnitudes, one bit per stage.
// Depends on ltq_pkg.
module ltq_search
  import ltq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  side_t           side_i,
  input  logic [RW-1:0]   rhs_x_i,
  input  logic [RW-1:0]   rhs_y_i,
  input  logic [SW-1:0]   s_i,
  input  logic [EW-1:0]   limit_i,
  output logic            valid_o,
  output side_t           side_o,
  output logic [QW-1:0]   qx_o,
  output logic [QW-1:0]   qy_o
);

  localparam int NSTEP = QW;

  typedef struct packed {
    logic [QW-1:0] q;
    logic [CW-1:0] a;
    logic [CW-1:0] y;
  } step_t;

  function automatic step_t srch_step(input step_t cur, input logic [RW-1:0] rhs,
                                      input logic [SW-1:0] s, input logic [EW-1:0] lim,
                                      input int j);
    logic [CW-1:0] t;
    logic [CW-1:0] test;
    logic [CW-1:0] sc;
    step_t nxt;
    sc   = CW'(s);
    t    = CW'(cur.q) + (CW'(1) << j);
    test = cur.a + (cur.y << (j + 2)) - (cur.y << 1) + (sc << (2 * j + 2))
         - (sc << (j + 2)) + sc;
    nxt  = cur;
    if ((t <= CW'(lim)) && (test <= CW'(rhs))) begin
      nxt.q = cur.q | (QW'(1) << j);
      nxt.a = cur.a + (cur.y << (j + 2)) + (sc << (2 * j + 2));
      nxt.y = cur.y + (sc << (j + 1));
    end
    return nxt;
  endfunction

  logic            v_q   [NSTEP];
  side_t           side_q[NSTEP];
  step_t           sx_q  [NSTEP];
  step_t           sy_q  [NSTEP];
  logic [RW-1:0]   rx_q  [NSTEP];
  logic [RW-1:0]   ry_q  [NSTEP];
  logic [SW-1:0]   s_q   [NSTEP];
  logic [EW-1:0]   lim_q [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_stage
    logic          cur_v;
    side_t         cur_side;
    step_t         cur_x;
    step_t         cur_y;
    logic [RW-1:0] cur_rx;
    logic [RW-1:0] cur_ry;
    logic [SW-1:0] cur_s;
    logic [EW-1:0] cur_lim;

    if (i == 0) begin : g_first
      assign cur_v    = valid_i;
      assign cur_side = side_i;
      assign cur_x    = '0;
      assign cur_y    = '0;
      assign cur_rx   = rhs_x_i;
      assign cur_ry   = rhs_y_i;
      assign cur_s    = s_i;
      assign cur_lim  = limit_i;
    end else begin : g_next
      assign cur_v    = v_q[i-1];
      assign cur_side = side_q[i-1];
      assign cur_x    = sx_q[i-1];
      assign cur_y    = sy_q[i-1];
      assign cur_rx   = rx_q[i-1];
      assign cur_ry   = ry_q[i-1];
      assign cur_s    = s_q[i-1];
      assign cur_lim  = lim_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= cur_side;
        sx_q[i]   <= srch_step(cur_x, cur_rx, cur_s, cur_lim, NSTEP - 1 - i);
        sy_q[i]   <= srch_step(cur_y, cur_ry, cur_s, cur_lim, NSTEP - 1 - i);
        rx_q[i]   <= cur_rx;
        ry_q[i]   <= cur_ry;
        s_q[i]    <= cur_s;
        lim_q[i]  <= cur_lim;
      end
    end
  end

  assign valid_o = v_q[NSTEP-1];
  assign side_o  = side_q[NSTEP-1];
  assign qx_o    = sx_q[NSTEP-1].q;
  assign qy_o    = sy_q[NSTEP-1].q;

endmodule

// ===== design/line_to_quad_expander_unit.sv =====
// Line segment to antialiased quad expander, top level.
// Path from input beat to first output beat: 4 setup stages,
// one search stage per offset bit, one output register stage.
// Throughput is set by six vertex beats per segment on the output port: the pipeline
// stalls while they are pending; a skipped segment takes one pipeline slot. Reset clears all
// valid bits and loads min_length_sq with 66. Depends on ltq_pkg, ltq_search.
module line_to_quad_expander_unit
  import ltq_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_BITS-1:0]          cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [WIDTH_BITS-1:0]        line_thickness_i,
  input  logic [RGBA_BITS-1:0]         rgba_i,
  input  logic                         batch_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic signed [COORD_BITS-1:0] vertex_x_o,
  output logic signed [COORD_BITS-1:0] vertex_y_o,
  output logic [WIDTH_BITS-1:0]        vertex_width_o,
  output logic signed [WIDTH_BITS:0]   edge_distance_o,
  output logic [RGBA_BITS-1:0]         vertex_rgba_o,
  output logic                         run_last_o,
  output logic                         batch_done_o
);

  localparam int SUMW = ((COORD_BITS > QW + 1) ? COORD_BITS : (QW + 1)) + 1;
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  function automatic logic signed [COORD_BITS-1:0] sat_add(
      input logic signed [COORD_BITS-1:0] c, input logic signed [QW:0] n);
    logic signed [SUMW-1:0] sum;
    sum = SUMW'(c) + SUMW'(n);
    if (sum > SUMW'(CMAX)) begin
      return CMAX;
    end else if (sum < SUMW'(CMIN)) begin
      return CMIN;
    end
    return COORD_BITS'(sum);
  endfunction

  logic [CFG_BITS-1:0] min_len_q;
  logic                en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RESET;
    end else if (cfg_valid_i) begin
      min_len_q <= cfg_data_i;
    end
  end

  // stage 1: differences and magnitudes
  logic signed [AW-1:0] dx, dy;
  logic                 p1_v_q;
  side_t                p1_side_q, p1_side_d;
  logic [AW-1:0]        a1_q, b1_q;

  always_comb begin
    dx = AW'(end_x_i) - AW'(start_x_i);
    dy = AW'(end_y_i) - AW'(start_y_i);
    p1_side_d       = '0;
    p1_side_d.sx    = start_x_i;
    p1_side_d.sy    = start_y_i;
    p1_side_d.ex    = end_x_i;
    p1_side_d.ey    = end_y_i;
    p1_side_d.w     = line_thickness_i;
    p1_side_d.rgba  = rgba_i;
    p1_side_d.last  = batch_last_i;
    p1_side_d.dxpos = (dx > 0);
    p1_side_d.dyneg = (dy < 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q <= p1_side_d;
      a1_q      <= dx[AW-1] ? AW'(-dx) : AW'(dx);
      b1_q      <= dy[AW-1] ? AW'(-dy) : AW'(dy);
    end
  end

  // stage 2: skip test and normalization
  logic [SQW-1:0]       sq;
  logic [AW-1:0]        orab;
  logic [KW-1:0]        len, k;
  side_t                p2_side_d, p2_side_q;
  logic                 p2_v_q;
  logic [NORM_BITS-1:0] as2_q, bs2_q;
  logic [EW-1:0]        e2_q;

  always_comb begin
    sq = SQW'(a1_q[SMALL_BITS-1:0]) * SQW'(a1_q[SMALL_BITS-1:0])
       + SQW'(b1_q[SMALL_BITS-1:0]) * SQW'(b1_q[SMALL_BITS-1:0]);
    orab = a1_q | b1_q;
    len  = '0;
    for (int i = 0; i < AW; i++) begin
      if (orab[i]) len = KW'(i + 1);
    end
    k = (len > KW'(NORM_BITS)) ? (len - KW'(NORM_BITS)) : '0;
    p2_side_d      = p1_side_q;
    p2_side_d.skip = ((a1_q >> SMALL_BITS) == '0) && ((b1_q >> SMALL_BITS) == '0)
                   && (sq < SQW'(min_len_q));
    p2_side_d.zero = (orab == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_side_q <= p2_side_d;
      as2_q     <= NORM_BITS'(a1_q >> k);
      bs2_q     <= NORM_BITS'(b1_q >> k);
      e2_q      <= EW'(p1_side_q.w) + EW'(EXPAND);
    end
  end

  // stage 3: squared norm and scaled numerators
  logic          p3_v_q;
  side_t         p3_side_q;
  logic [SW-1:0] s3_q;
  logic [PW-1:0] px3_q, py3_q;
  logic [EW-1:0] e3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_side_q <= p2_side_q;
      s3_q      <= SW'(as2_q) * SW'(as2_q) + SW'(bs2_q) * SW'(bs2_q);
      px3_q     <= PW'(bs2_q) * PW'(e2_q);
      py3_q     <= PW'(as2_q) * PW'(e2_q);
      e3_q      <= e2_q;
    end
  end

  // stage 4: right-hand sides of the search compare
  logic          p4_v_q;
  side_t         p4_side_q;
  logic [SW-1:0] s4_q;
  logic [RW-1:0] rx4_q, ry4_q;
  logic [EW-1:0] lim4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (en) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_side_q <= p3_side_q;
      s4_q      <= s3_q;
      rx4_q     <= RW'(px3_q) * RW'(px3_q);
      ry4_q     <= RW'(py3_q) * RW'(py3_q);
      lim4_q    <= (e3_q >> 1) + EW'(1);
    end
  end

  logic          so_v;
  side_t         so_side;
  logic [QW-1:0] qx, qy;

  ltq_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p4_v_q),
    .side_i  (p4_side_q),
    .rhs_x_i (rx4_q),
    .rhs_y_i (ry4_q),
    .s_i     (s4_q),
    .limit_i (lim4_q),
    .valid_o (so_v),
    .side_o  (so_side),
    .qx_o    (qx),
    .qy_o    (qy)
  );

  // output stage: corners and six-beat sequencer
  logic                         ser_valid_q, ser_valid_d;
  logic                         ser_free;
  logic [2:0]                   idx_q, idx_d;
  logic                         marker_q;
  logic                         last_q;
  logic signed [COORD_BITS-1:0] cx_q [4];
  logic signed [COORD_BITS-1:0] cy_q [4];
  logic [WIDTH_BITS:0]          dmag_q;
  logic [WIDTH_BITS-1:0]        w_q;
  logic [RGBA_BITS-1:0]         rgba_q;
  logic signed [QW:0]           nx, ny;
  logic [EW-1:0]                e_out;
  logic                         beat_end;
  logic [1:0]                   corner;

  assign beat_end = marker_q || (idx_q == 3'd5);
  assign ser_free = !ser_valid_q || (!out_stall_i && beat_end);
  assign en       = !so_v || ser_free;
  assign in_stall_o = !en;

  always_comb begin
    nx = signed'({1'b0, qx});
    ny = signed'({1'b0, qy});
    if (so_side.dyneg) nx = -nx;
    if (so_side.dxpos) ny = -ny;
    if (so_side.zero) begin
      nx = '0;
      ny = '0;
    end
    e_out = EW'(so_side.w) + EW'(EXPAND);
    ser_valid_d = ser_valid_q;
    idx_d       = idx_q;
    if (ser_free) begin
      ser_valid_d = so_v && !(so_side.skip && !so_side.last);
      idx_d       = '0;
    end else if (ser_valid_q && !out_stall_i) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      ser_valid_q <= ser_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_free) begin
      marker_q <= so_side.skip;
      last_q   <= so_side.last;
      w_q      <= so_side.w;
      rgba_q   <= so_side.rgba;
      dmag_q   <= (WIDTH_BITS+1)'(e_out >> 1);
      cx_q[0]  <= sat_add(so_side.sx, nx);
      cy_q[0]  <= sat_add(so_side.sy, ny);
      cx_q[1]  <= sat_add(so_side.ex, nx);
      cy_q[1]  <= sat_add(so_side.ey, ny);
      cx_q[2]  <= sat_add(so_side.ex, -nx);
      cy_q[2]  <= sat_add(so_side.ey, -ny);
      cx_q[3]  <= sat_add(so_side.sx, -nx);
      cy_q[3]  <= sat_add(so_side.sy, -ny);
    end
  end

  always_comb begin
    case (idx_q)
      3'd0:    corner = 2'd0;
      3'd1:    corner = 2'd1;
      3'd2:    corner = 2'd2;
      3'd3:    corner = 2'd2;
      3'd4:    corner = 2'd3;
      default: corner = 2'd0;
    endcase
  end

  assign out_valid_o = ser_valid_q;

  always_comb begin
    if (marker_q) begin
      kind_o          = 1'b1;
      vertex_x_o      = '0;
      vertex_y_o      = '0;
      vertex_width_o  = '0;
      edge_distance_o = '0;
      vertex_rgba_o   = '0;
      run_last_o      = 1'b1;
      batch_done_o    = 1'b1;
    end else begin
      kind_o          = 1'b0;
      vertex_x_o      = cx_q[corner];
      vertex_y_o      = cy_q[corner];
      vertex_width_o  = w_q;
      edge_distance_o = corner[1] ? -signed'(dmag_q) : signed'(dmag_q);
      vertex_rgba_o   = rgba_q;
      run_last_o      = (idx_q == 3'd5);
      batch_done_o    = (idx_q == 3'd5) && last_q;
    end
  end

endmodule

// ===== tb/tb_line_to_quad_expander_unit.sv =====
// Self-checking testbench for line_to_quad_expander_unit: segments in, quad vertices out.
// Holds its own fixed-point quad predictor and a queue of expected vertex beats.
// Depends on ltq_pkg and the line_to_quad_expander_unit RTL.
module tb_line_to_quad_expander_unit;
  import ltq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 300;

  typedef struct {
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [WIDTH_BITS-1:0]        w;
    logic [RGBA_BITS-1:0]         rgba;
    logic                         last;
  } seg_t;

  typedef struct {
    logic                         kind;
    logic signed [COORD_BITS-1:0] x, y;
    logic [WIDTH_BITS-1:0]        w;
    logic signed [WIDTH_BITS:0]   edist;
    logic [RGBA_BITS-1:0]         rgba;
    logic                         run_last, batch_done;
  } vtx_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_BITS-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic signed [COORD_BITS-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic [WIDTH_BITS-1:0] line_thickness_i;
  logic [RGBA_BITS-1:0] rgba_i;
  logic batch_last_i;
  logic out_valid_o, out_stall_i;
  logic kind_o;
  logic signed [COORD_BITS-1:0] vertex_x_o, vertex_y_o;
  logic [WIDTH_BITS-1:0] vertex_width_o;
  logic signed [WIDTH_BITS:0] edge_distance_o;
  logic [RGBA_BITS-1:0] vertex_rgba_o;
  logic run_last_o, batch_done_o;

  line_to_quad_expander_unit u_dut (.*);

  vtx_t vtx_q[$];
  logic [CFG_BITS-1:0] min_len_sq;
  int snd_pct, rcv_pct;
  int fails = 0;
  int beats_seen = 0;
  int markers_seen = 0;
  int segs_sent;
  int hold_left;
  int hold_req_cnt;
  int hold_ack_cnt;
  int idle_cnt = 0;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic longint sat24(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  function automatic longint unsigned axis_offset(longint unsigned m, longint unsigned s,
                                                  longint unsigned e);
    longint unsigned rhs, lim, q, t, k, bitv;
    rhs = m * m * (e * e);
    lim = (e >> 1) + 1;
    q = 0;
    bitv = 64'd1 << WIDTH_BITS;
    while (bitv != 0) begin
      t = q | bitv;
      if (t <= lim) begin
        k = 2 * t - 1;
        if (k * k * s <= rhs) q = t;
      end
      bitv >>= 1;
    end
    return q;
  endfunction

  function automatic void push_exp(vtx_t v);
    vtx_q.insert(vtx_q.size(), v);
  endfunction

  function automatic void predict_quad(seg_t g);
    longint sx, sy, ex, ey, dx, dy, nx, ny, d;
    longint unsigned a, b, e, as_, bs_, s;
    longint px[4], py[4];
    int order[6];
    int k, c;
    vtx_t v;
    order = '{0, 1, 2, 2, 3, 0};
    sx = longint'(g.sx); sy = longint'(g.sy); ex = longint'(g.ex); ey = longint'(g.ey);
    dx = ex - sx; dy = ey - sy;
    a = (dx < 0) ? -dx : dx;
    b = (dy < 0) ? -dy : dy;
    e = 64'(g.w) + 64'(EXPAND);
    d = e >> 1;
    nx = 0; ny = 0;
    if (a < 4096 && b < 4096 && a * a + b * b < 64'(min_len_sq)) begin
      if (g.last) begin
        v = '{kind: 1'b1, x: '0, y: '0, w: '0, edist: '0, rgba: '0,
              run_last: 1'b1, batch_done: 1'b1};
        push_exp(v);
      end
      return;
    end
    if (a != 0 || b != 0) begin
      k = 0;
      while ((a >> k) >= (64'd1 << NORM_BITS) || (b >> k) >= (64'd1 << NORM_BITS)) k++;
      as_ = a >> k;
      bs_ = b >> k;
      s = as_ * as_ + bs_ * bs_;
      nx = axis_offset(bs_, s, e);
      ny = axis_offset(as_, s, e);
      if (dy < 0) nx = -nx;
      if (dx > 0) ny = -ny;
    end
    px[0] = sat24(sx + nx); py[0] = sat24(sy + ny);
    px[1] = sat24(ex + nx); py[1] = sat24(ey + ny);
    px[2] = sat24(ex - nx); py[2] = sat24(ey - ny);
    px[3] = sat24(sx - nx); py[3] = sat24(sy - ny);
    for (int i = 0; i < 6; i++) begin
      c = order[i];
      v.kind = 1'b0;
      v.x = COORD_BITS'(px[c]);
      v.y = COORD_BITS'(py[c]);
      v.w = g.w;
      v.edist = (WIDTH_BITS+1)'((c < 2) ? d : -d);
      v.rgba = g.rgba;
      v.run_last = (i == 5);
      v.batch_done = (i == 5) && g.last;
      push_exp(v);
    end
  endfunction

  function automatic void cmp_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      fails++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, expv, actv);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    vtx_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (kind_o) markers_seen++;
      if (vtx_q.size() == 0) begin
        fails++;
        $display("%0t unexpected beat: expected none actual x=%0h y=%0h", $time,
                 vertex_x_o, vertex_y_o);
      end else begin
        x = vtx_q.pop_front();
        cmp_field("kind", longint'(x.kind), longint'(kind_o));
        cmp_field("vertex_x", longint'(x.x), longint'(vertex_x_o));
        cmp_field("vertex_y", longint'(x.y), longint'(vertex_y_o));
        cmp_field("vertex_width", longint'(x.w), longint'(vertex_width_o));
        cmp_field("edge_distance", longint'(x.edist), longint'(edge_distance_o));
        cmp_field("vertex_rgba", longint'(x.rgba), longint'(vertex_rgba_o));
        cmp_field("run_last", longint'(x.run_last), longint'(run_last_o));
        cmp_field("batch_done", longint'(x.batch_done), longint'(batch_done_o));
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_ack_cnt <= 0;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cnt);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic send_seg(seg_t g);
    while ($urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    start_x_i <= g.sx;
    start_y_i <= g.sy;
    end_x_i <= g.ex;
    end_y_i <= g.ey;
    line_thickness_i <= g.w;
    rgba_i <= g.rgba;
    batch_last_i <= g.last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_quad(g);
    segs_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (vtx_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_len(logic [CFG_BITS-1:0] val);
    drain();
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    min_len_sq = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic seg_t mk_seg(longint sx, longint sy, longint ex, longint ey,
                                  int w, bit last);
    seg_t g;
    g.sx = COORD_BITS'(sx); g.sy = COORD_BITS'(sy);
    g.ex = COORD_BITS'(ex); g.ey = COORD_BITS'(ey);
    g.w = WIDTH_BITS'(w);
    g.rgba = $urandom();
    g.last = last;
    return g;
  endfunction

  function automatic seg_t rand_seg();
    seg_t g;
    longint cx, cy, span;
    int mode;
    mode = $urandom_range(9);
    g.sx = COORD_BITS'($urandom());
    g.sy = COORD_BITS'($urandom());
    cx = longint'(g.sx); cy = longint'(g.sy);
    span = (mode < 2) ? 24 : (mode < 7) ? 4000 : 0;
    if (span == 0) begin
      g.ex = COORD_BITS'($urandom());
      g.ey = COORD_BITS'($urandom());
    end else begin
      g.ex = COORD_BITS'(sat24(cx + longint'($urandom_range(32'(2 * span))) - span));
      g.ey = COORD_BITS'(sat24(cy + longint'($urandom_range(32'(2 * span))) - span));
    end
    g.w = WIDTH_BITS'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(2048));
    g.rgba = $urandom();
    g.last = ($urandom_range(4) == 0);
    return g;
  endfunction

  task automatic test_directed;
    longint mx, mn;
    mx = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    mn = -mx - 1;
    send_seg(mk_seg(0, 0, 2560, 0, 256, 0));
    send_seg(mk_seg(0, 0, 0, -2560, 256, 0));
    send_seg(mk_seg(100, 100, -900, -900, 0, 1));
    send_seg(mk_seg(0, 0, 8, 0, 512, 0));
    send_seg(mk_seg(0, 0, 8, 0, 512, 1));
    send_seg(mk_seg(0, 0, 9, 0, 512, 1));
    send_seg(mk_seg(mn, mn, mx, mx, 65535, 1));
    send_seg(mk_seg(mx, mn, mn, mx, 65535, 0));
    send_seg(mk_seg(mx, mx, mx - 4096, mx, 4000, 0));
    send_seg(mk_seg(mn, mn, mn, mn + 4095, 4000, 1));
    send_seg(mk_seg(mn, 0, mx, 1, 12345, 0));
    send_seg(mk_seg(7, 7, 7, 7, 100, 1));
    drain();
    write_min_len('0);
    send_seg(mk_seg(7, 7, 7, 7, 100, 1));
    send_seg(mk_seg(mx, mn, mx, mn, 65535, 0));
    send_seg(mk_seg(0, 0, 1, 0, 0, 1));
    write_min_len('1);
    send_seg(mk_seg(0, 0, 4095, 4095, 300, 1));
    send_seg(mk_seg(0, 0, 4095, 4095, 300, 0));
    send_seg(mk_seg(0, 0, 4096, 0, 300, 1));
    send_seg(mk_seg(0, 0, 0, -4096, 300, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_seg(rand_seg());
  endtask

  task automatic test_backpressure;
    snd_pct = 0;
    hold_req_cnt++;
    test_random(24);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    start_x_i = '0; start_y_i = '0; end_x_i = '0; end_y_i = '0;
    line_thickness_i = '0;
    rgba_i = '0;
    batch_last_i = 1'b0;
    hold_req_cnt = 0;
    segs_sent = 0;
    min_len_sq = MIN_LEN_RESET;
    snd_pct = 27;
    rcv_pct = 51;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_min_len(MIN_LEN_RESET);
    test_random(100);
    write_min_len(24'd5000);
    snd_pct = 51;
    rcv_pct = 27;
    test_random(100);
    write_min_len(24'h3FFFFF);
    snd_pct = 0;
    rcv_pct = 0;
    test_random(100);
    test_backpressure();

    drain();
    $display("Sent %0d segments (directed, random, back-pressure) over five thresholds;",
             segs_sent);
    $display("checked %0d output beats, %0d of them batch-end markers.", beats_seen,
             markers_seen);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
